[rtl/core/tmlr_pkg.sv]
// ----------------------------------------------------------------------------
// tmlr_pkg
// shared constants and types for the thick midpoint line rasterizer
// ----------------------------------------------------------------------------
package tmlr_pkg;

  // defaults for the top level parameters
  localparam int COORD_BITS_DEF    = 4;
  localparam int MAX_HALF_SPAN_DEF = 1;

  // fixed field widths on the stream ports
  localparam int COORD_W = 4;
  localparam int PIX_Y_W = 6;
  localparam int THICK_W = 2;

  // span offset counter, covers -1..1
  localparam int K_W = 2;

  // shared adder operation
  typedef logic alu_op_t;
  localparam alu_op_t ALU_ADD = 1'b0;
  localparam alu_op_t ALU_SUB = 1'b1;

endpackage

[rtl/core/tmlr_alu.sv]
// ----------------------------------------------------------------------------
// tmlr_alu
// shared add / subtract unit used by the rasterizer sequencer
// ----------------------------------------------------------------------------
module tmlr_alu #(
  parameter int W = 8
) (
  input  logic             [W-1:0] a,
  input  logic             [W-1:0] b,
  input  tmlr_pkg::alu_op_t        op,
  output logic             [W-1:0] sum
);
  import tmlr_pkg::*;

  logic [W-1:0] b_eff;
  logic [W-1:0] carry_in;

  always_comb begin
    b_eff    = (op == ALU_SUB) ? ~b : b;
    carry_in = {{(W-1){1'b0}}, (op == ALU_SUB)};
    sum      = a + b_eff + carry_in;
  end

endmodule

[rtl/core/thick_midpoint_line_rasterizer_top.sv]
// ----------------------------------------------------------------------------
// thick_midpoint_line_rasterizer_top
// walks one line request column by column with the midpoint decision
// variable and streams a vertical span of pixels for every column
// ----------------------------------------------------------------------------
// first pixel: 6 setup steps on the shared adder after the request transfer,
// then the emit state loads the output register
// per request: cols*(2h+1) pixels, cols = end_x-start_x+1 (1 if end is left),
// h = half span; each pixel and column step is one pass through the single
// shared adder; a new request is taken only in idle, after the last pixel
// reset: rst (synchronous) returns the sequencer to idle and drops m_tvalid
module thick_midpoint_line_rasterizer_top #(
  parameter int COORD_BITS    = tmlr_pkg::COORD_BITS_DEF,
  parameter int MAX_HALF_SPAN = tmlr_pkg::MAX_HALF_SPAN_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_x[3:0], start_y[7:4], end_x[11:8], end_y[15:12], thickness[17:16]
  input  logic [23:0] s_tdata,
  output logic        m_tvalid,
  input  logic        m_tready,
  // pixel_x[3:0], pixel_y[9:4]
  output logic [15:0] m_tdata,
  output logic        m_tlast
);
  import tmlr_pkg::*;

  localparam int DW = COORD_BITS + 4;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_RUN   = 4'd1;
  localparam logic [3:0] ST_RISE  = 4'd2;
  localparam logic [3:0] ST_INCE  = 4'd3;
  localparam logic [3:0] ST_DEC   = 4'd4;
  localparam logic [3:0] ST_DIFF  = 4'd5;
  localparam logic [3:0] ST_INCNE = 4'd6;
  localparam logic [3:0] ST_EMIT  = 4'd7;
  localparam logic [3:0] ST_ADV   = 4'd8;

  logic [3:0] state;

  logic [COORD_BITS-1:0] cx;
  logic [COORD_BITS-1:0] cy;
  logic [COORD_BITS-1:0] x1;
  logic [COORD_BITS-1:0] y1;
  logic                  half;
  logic                  step_up;
  logic [K_W-1:0]        k;

  logic [DW-1:0] run;
  logic [DW-1:0] rise;
  logic [DW-1:0] inc_e;
  logic [DW-1:0] inc_ne;
  logic [DW-1:0] dec;

  logic [DW-1:0] alu_a;
  logic [DW-1:0] alu_b;
  alu_op_t       alu_op;
  logic [DW-1:0] alu_sum;

  logic          more;
  logic          dec_le0;
  logic          y_up;
  logic          k_at_top;
  logic          out_load;
  logic [K_W-1:0] k_start;
  logic [K_W-1:0] k_top;

  function automatic logic [DW-1:0] zext_c(input logic [COORD_BITS-1:0] v);
    zext_c = {{(DW-COORD_BITS){1'b0}}, v};
  endfunction

  tmlr_alu #(
    .W (DW)
  ) u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .op  (alu_op),
    .sum (alu_sum)
  );

  assign s_tready = (state == ST_IDLE);
  assign more     = (cx < x1);
  assign dec_le0  = dec[DW-1] | (dec == '0);
  assign y_up     = (y1 > cy);
  assign k_start  = half ? {K_W{1'b1}} : '0;
  assign k_top    = {{(K_W-1){1'b0}}, half};
  assign k_at_top = (k == k_top);
  assign out_load = !m_tvalid || m_tready;

  // operand selection for the shared adder
  always_comb begin
    alu_a  = '0;
    alu_b  = '0;
    alu_op = ALU_ADD;
    unique case (state)
      ST_RUN: begin
        alu_a  = zext_c(x1);
        alu_b  = zext_c(cx);
        alu_op = ALU_SUB;
      end
      ST_RISE: begin
        alu_a  = y_up ? zext_c(y1) : zext_c(cy);
        alu_b  = y_up ? zext_c(cy) : zext_c(y1);
        alu_op = ALU_SUB;
      end
      ST_INCE: begin
        alu_a = rise;
        alu_b = rise;
      end
      ST_DEC: begin
        alu_a  = inc_e;
        alu_b  = run;
        alu_op = ALU_SUB;
      end
      ST_DIFF: begin
        alu_a  = rise;
        alu_b  = run;
        alu_op = ALU_SUB;
      end
      ST_INCNE: begin
        alu_a = inc_ne;
        alu_b = inc_ne;
      end
      ST_EMIT: begin
        alu_a = zext_c(cy);
        alu_b = {{(DW-K_W){k[K_W-1]}}, k};
      end
      ST_ADV: begin
        alu_a = dec;
        alu_b = dec_le0 ? inc_e : inc_ne;
      end
      default: begin
        alu_a  = '0;
        alu_b  = '0;
        alu_op = ALU_ADD;
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            state <= ST_RUN;
          end
        end
        ST_RUN:   state <= ST_RISE;
        ST_RISE:  state <= ST_INCE;
        ST_INCE:  state <= ST_DEC;
        ST_DEC:   state <= ST_DIFF;
        ST_DIFF:  state <= ST_INCNE;
        ST_INCNE: state <= ST_EMIT;
        ST_EMIT: begin
          if (out_load && k_at_top) begin
            state <= more ? ST_ADV : ST_IDLE;
          end
        end
        ST_ADV:   state <= ST_EMIT;
        default:  state <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          cx   <= s_tdata[COORD_BITS-1:0];
          cy   <= s_tdata[4 +: COORD_BITS];
          x1   <= s_tdata[8 +: COORD_BITS];
          y1   <= s_tdata[12 +: COORD_BITS];
          half <= (MAX_HALF_SPAN > 0) ? s_tdata[17] : 1'b0;
        end
      end
      ST_RUN:   run <= alu_sum;
      ST_RISE: begin
        rise    <= alu_sum;
        step_up <= y_up;
      end
      ST_INCE:  inc_e <= alu_sum;
      ST_DEC:   dec <= alu_sum;
      ST_DIFF:  inc_ne <= alu_sum;
      ST_INCNE: begin
        inc_ne <= alu_sum;
        k      <= k_start;
      end
      ST_EMIT: begin
        if (out_load) begin
          k <= k + {{(K_W-1){1'b0}}, 1'b1};
        end
      end
      ST_ADV: begin
        dec <= alu_sum;
        cx  <= cx + {{(COORD_BITS-1){1'b0}}, 1'b1};
        if (!dec_le0) begin
          cy <= step_up ? cy + {{(COORD_BITS-1){1'b0}}, 1'b1}
                        : cy - {{(COORD_BITS-1){1'b0}}, 1'b1};
        end
        k <= k_start;
      end
      default: begin
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (state == ST_EMIT && out_load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_EMIT && out_load) begin
      m_tdata <= {6'd0, alu_sum[PIX_Y_W-1:0],
                  {(COORD_W-COORD_BITS){1'b0}}, cx};
      m_tlast <= !more && k_at_top;
    end
  end

endmodule

[bench/thick_midpoint_line_rasterizer_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// thick_midpoint_line_rasterizer_top_tb
// sends line requests on the slave stream and predicts every pixel of each
// line's thick span walk; pixels on the master stream are checked in order
// against the predicted queue, with random gaps on both streams
// ----------------------------------------------------------------------------
module thick_midpoint_line_rasterizer_top_tb;
  import tmlr_pkg::*;

  localparam int COORD_BITS    = COORD_BITS_DEF;
  localparam int MAX_HALF_SPAN = MAX_HALF_SPAN_DEF;
  localparam int RANDOM_LINES  = 280;

  typedef struct packed {
    logic [THICK_W-1:0] thick;
    logic [COORD_W-1:0] ey;
    logic [COORD_W-1:0] ex;
    logic [COORD_W-1:0] sy;
    logic [COORD_W-1:0] sx;
  } line_req_t;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [PIX_Y_W-1:0] y;
    logic               last;
  } pixel_t;

  class pixel_scoreboard;
    pixel_t      expected_q[$];
    int unsigned errors = 0;

    // walk the line x-major and queue every span pixel, lowest row first
    function void add_line(line_req_t req);
      int x0, y0, x1, y1, half, run, rise, stp, dec, inc_e, inc_ne, cx, cy;
      bit more;
      pixel_t p;
      x0 = int'(req.sx) & ((1 << COORD_BITS) - 1);
      y0 = int'(req.sy) & ((1 << COORD_BITS) - 1);
      x1 = int'(req.ex) & ((1 << COORD_BITS) - 1);
      y1 = int'(req.ey) & ((1 << COORD_BITS) - 1);
      half = int'(req.thick) >> 1;
      if (half > MAX_HALF_SPAN) half = MAX_HALF_SPAN;
      run    = x1 - x0;
      stp    = (y1 > y0) ? 1 : -1;
      rise   = stp * (y1 - y0);
      dec    = 2 * rise - run;
      inc_e  = 2 * rise;
      inc_ne = 2 * (rise - run);
      cx = x0;
      cy = y0;
      do begin
        more = (cx < x1);
        for (int k = -half; k <= half; k++) begin
          p.x    = COORD_W'(cx);
          p.y    = PIX_Y_W'(cy + k);
          p.last = !more && (k == half);
          expected_q.push_back(p);
        end
        if (more) begin
          if (dec <= 0) begin
            dec += inc_e;
          end else begin
            dec += inc_ne;
            cy  += stp;
          end
          cx++;
        end
      end while (more);
    endfunction

    function void report(string what, pixel_t want, pixel_t got);
      errors++;
      if (errors <= 10)
        $display("%0t %s: expected x=%0d y=%0d last=%0b, got x=%0d y=%0d last=%0b",
                 $realtime, what, want.x, $signed(want.y), want.last,
                 got.x, $signed(got.y), got.last);
    endfunction

    function void check_pixel(pixel_t got);
      pixel_t want;
      want = '0;
      if (expected_q.size() == 0) begin
        report("unexpected pixel", want, got);
        return;
      end
      want = expected_q.pop_front();
      if (got.x !== want.x || got.y !== want.y || got.last !== want.last)
        report("pixel mismatch", want, got);
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic        clk;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [23:0] s_tdata  = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  pixel_scoreboard sb;
  bit          src_quiet = 1'b0;
  bit          snk_quiet = 1'b0;
  int          snk_hold  = 0;
  int unsigned snk_cycle = 0;

  thick_midpoint_line_rasterizer_top #(
    .COORD_BITS    (COORD_BITS),
    .MAX_HALF_SPAN (MAX_HALF_SPAN)
  ) i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short gaps, now and then a long one
  function automatic int pick_gap(bit quiet);
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 16);
  endfunction

  function automatic line_req_t mk_line(int sx, int sy, int ex, int ey, int th);
    line_req_t req;
    req.sx    = COORD_W'(sx);
    req.sy    = COORD_W'(sy);
    req.ex    = COORD_W'(ex);
    req.ey    = COORD_W'(ey);
    req.thick = THICK_W'(th);
    return req;
  endfunction

  // valid stays high across back-to-back requests
  task automatic send_line(line_req_t req);
    int gap;
    gap = pick_gap(src_quiet);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, req};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.add_line(req);
  endtask

  // pixel sink: check each transfer, then choose ready for the next cycle
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_pixel({m_tdata[COORD_W-1:0], m_tdata[COORD_W +: PIX_Y_W], m_tlast});
    snk_cycle++;
    if (snk_cycle % 200 == 0) snk_quiet = ($urandom_range(0, 3) == 0);
    if (snk_hold > 0) begin
      snk_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      snk_hold = pick_gap(snk_quiet);
    end
  end

  initial begin
    line_req_t req;
    int sx;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_line(mk_line(0, 0, 0, 0, 0));
    send_line(mk_line(15, 15, 15, 15, 3));
    send_line(mk_line(0, 0, 15, 0, 3));      // span dips below row 0
    send_line(mk_line(0, 15, 15, 15, 2));    // span rises above the grid
    send_line(mk_line(0, 0, 15, 15, 1));
    send_line(mk_line(0, 15, 15, 0, 3));
    send_line(mk_line(15, 0, 0, 15, 3));     // end left of start
    send_line(mk_line(7, 3, 7, 12, 2));      // same column
    send_line(mk_line(2, 1, 5, 14, 2));      // steep up
    send_line(mk_line(3, 14, 6, 0, 3));      // steep down
    send_line(mk_line(0, 4, 15, 9, 0));
    send_line(mk_line(1, 10, 13, 6, 1));
    send_line(mk_line(4, 8, 12, 8, 0));
    send_line(mk_line(0, 0, 1, 1, 2));
    send_line(mk_line(14, 15, 15, 0, 3));
    send_line(mk_line(5, 5, 4, 5, 0));
    send_line(mk_line(9, 2, 10, 2, 3));
    send_line(mk_line(0, 7, 15, 8, 2));
    send_line(mk_line(8, 0, 15, 15, 3));
    send_line(mk_line(15, 15, 0, 0, 0));
    send_line(mk_line(6, 9, 11, 9, 1));

    for (int i = 0; i < RANDOM_LINES; i++) begin
      if (i % 40 == 0) src_quiet = ($urandom_range(0, 2) == 0);
      // mostly forward lines so the column walk gets exercised
      if ($urandom_range(0, 3) != 0) begin
        sx  = $urandom_range(0, 15);
        req = mk_line(sx, $urandom_range(0, 15), $urandom_range(sx, 15),
                      $urandom_range(0, 15), $urandom_range(0, 3));
      end else begin
        req = mk_line($urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 15), $urandom_range(0, 15),
                      $urandom_range(0, 3));
      end
      send_line(req);
    end
    s_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule

[filelist.f]
rtl/core/tmlr_pkg.sv
rtl/core/tmlr_alu.sv
rtl/core/thick_midpoint_line_rasterizer_top.sv
bench/thick_midpoint_line_rasterizer_top_tb.sv
